[hw/rtl/s2i_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_pkg
// Shared types, constants and a helper function of the string to integer parser.
// ----------------------------------------------------------------------------
package s2i_pkg;

    // Default accumulator width; the top level can override it.
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed widths of the result fields and the configuration port.
    localparam int RESULT_WIDTH  = 32;
    localparam int COUNT_WIDTH   = 16;
    localparam int CHAR_WIDTH    = 8;
    localparam int RADIX_WIDTH   = 6;
    localparam int DIGIT_WIDTH   = 7;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET  = 6'd10;
    localparam logic                   SIGNED_RESET = 1'b1;

    // Bases that prefix detection picks.
    localparam logic [RADIX_WIDTH-1:0] BASE_AUTO = 6'd0;
    localparam logic [RADIX_WIDTH-1:0] BASE_OCT  = 6'd8;
    localparam logic [RADIX_WIDTH-1:0] BASE_DEC  = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] BASE_HEX  = 6'd16;

    // Characters with a special meaning.
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;

    // Digit value of a character that is no letter or digit.
    localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT = 7'd64;

    // Saturation limit of the consumed count.
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Conversion phases.
    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_START  = 2'd1,
        PH_ZERO   = 2'd2,
        PH_DIGITS = 2'd3
    } t_phase;

    // Configuration register contents.
    typedef struct packed {
        logic [RADIX_WIDTH-1:0] radix;
        logic                   signed_mode;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [RESULT_WIDTH-1:0] value;
        logic [COUNT_WIDTH-1:0]  consumed;
        logic                    converted;
    } t_result;

    // A result beat handed from the core to the output stage.
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_beat;

    // Digit value of a character: 0-9 for digits, 10-35 for letters.
    function automatic logic [DIGIT_WIDTH-1:0] digit_of(input logic [CHAR_WIDTH-1:0] c);
        logic [CHAR_WIDTH-1:0] d;
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end else begin
            d = {1'b0, NO_DIGIT};
        end
        return d[DIGIT_WIDTH-1:0];
    endfunction

endpackage

[hw/rtl/s2i_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_if
// Valid/ready channels of the parser: characters in, results out, and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface s2i_char_if import s2i_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface s2i_result_if import s2i_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [RESULT_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]  consumed;
    logic                    converted;

    modport source (output valid, output value, output consumed, output converted,
                    input ready);
    modport sink   (input valid, input value, input consumed, input converted,
                    output ready);
endinterface

interface s2i_cfg_if import s2i_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/s2i_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_cfg_regs
// Configuration registers: radix and signed mode, written through the
// configuration channel.
// ----------------------------------------------------------------------------
module s2i_cfg_regs import s2i_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [CFG_INDEX_W-1:0] i_index,
    input  logic [CFG_DATA_W-1:0]  i_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are taken in every cycle.
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    // Register decode; indexes past the list are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            unique case (i_index)
                CFG_RADIX:       n_cfg.radix       = i_data[RADIX_WIDTH-1:0];
                CFG_SIGNED_MODE: n_cfg.signed_mode = i_data[0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix       <= RADIX_RESET;
            r_cfg.signed_mode <= SIGNED_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hw/rtl/s2i_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_core
// Per-character conversion step: classifies the character, advances the phase,
// updates accumulator and count, and produces the result beat that ends a number.
// ----------------------------------------------------------------------------
module s2i_core import s2i_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CHAR_WIDTH-1:0] i_char,
    input  t_cfg                  i_cfg,
    output t_res_beat             o_beat,
    input  logic                  i_beat_ready
);

    // Number state.
    t_phase                   r_phase, n_phase;
    logic                     r_neg, n_neg;
    logic [VALUE_WIDTH-1:0]   r_acc, n_acc;
    logic [RADIX_WIDTH-1:0]   r_base, n_base;
    logic [COUNT_WIDTH-1:0]   r_count, n_count;
    logic                     r_any, n_any;

    // Step decode.
    logic                     w_accept;
    logic                     w_is_ws;
    logic                     w_is_sign;
    logic                     w_is_x;
    logic                     w_take_ws;
    logic                     w_take_sign;
    logic                     w_at_start;
    logic                     w_take_zero;
    logic                     w_take_x;
    logic                     w_digit_phase;
    logic                     w_take_digit;
    logic                     w_emit;
    logic [RADIX_WIDTH-1:0]   w_base;
    logic [DIGIT_WIDTH-1:0]   w_digit;
    logic [COUNT_WIDTH-1:0]   w_count_inc;
    logic [VALUE_WIDTH-1:0]   w_mac;
    logic [VALUE_WIDTH-1:0]   w_final;
    logic [RESULT_WIDTH-1:0]  w_value;

    // A character is taken whenever the output stage can hold a result.
    assign o_ready  = i_beat_ready;
    assign w_accept = i_valid && o_ready;

    // Character classes.
    assign w_is_ws   = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_LF);
    assign w_is_sign = (i_char == CH_PLUS) || ((i_char == CH_MINUS) && i_cfg.signed_mode);
    assign w_is_x    = (i_char == CH_LO_X) || (i_char == CH_UP_X);
    assign w_digit   = digit_of(i_char);

    // Which rule applies to this character, depending on the phase.
    always_comb begin
        w_take_ws     = 1'b0;
        w_take_sign   = 1'b0;
        w_at_start    = 1'b0;
        w_take_x      = 1'b0;
        w_digit_phase = 1'b0;
        unique case (r_phase)
            PH_SPACE: begin
                w_take_ws   = w_is_ws;
                w_take_sign = !w_is_ws && w_is_sign;
                w_at_start  = !w_is_ws && !w_is_sign;
            end
            PH_START: begin
                w_at_start = 1'b1;
            end
            PH_ZERO: begin
                w_take_x      = w_is_x;
                w_digit_phase = !w_is_x;
            end
            PH_DIGITS: begin
                w_digit_phase = 1'b1;
            end
            default: begin
                w_at_start = 1'b0;
            end
        endcase

        // A leading zero opens a prefix only when the radix is auto-detect or hex.
        w_take_zero = w_at_start && (i_char == CH_ZERO)
                      && ((i_cfg.radix == BASE_AUTO) || (i_cfg.radix == BASE_HEX));
        if (w_at_start && !w_take_zero) begin
            w_digit_phase = 1'b1;
        end

        // The radix is latched with the first character after the sign.
        if (w_at_start) begin
            w_base = (i_cfg.radix == BASE_AUTO) ? BASE_DEC : i_cfg.radix;
        end else begin
            w_base = r_base;
        end

        w_take_digit = w_digit_phase && (w_digit < {1'b0, w_base});
        w_emit       = w_digit_phase && !w_take_digit;
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            if (w_emit) begin
                n_phase = PH_SPACE;
            end else if (w_take_sign) begin
                n_phase = PH_START;
            end else if (w_take_zero) begin
                n_phase = PH_ZERO;
            end else if (w_take_x || w_take_digit) begin
                n_phase = PH_DIGITS;
            end
        end
    end

    // Multiply-add of the accumulator, wrapping at the accumulator width.
    assign w_mac       = r_acc * VALUE_WIDTH'(w_base) + VALUE_WIDTH'(w_digit);
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    // Next values of the number state.
    always_comb begin
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_base  = r_base;
        n_count = r_count;
        n_any   = r_any;
        if (w_accept) begin
            if (w_emit) begin
                n_neg   = 1'b0;
                n_acc   = '0;
                n_base  = '0;
                n_count = '0;
                n_any   = 1'b0;
            end else if (w_take_ws) begin
                n_count = w_count_inc;
            end else if (w_take_sign) begin
                n_neg   = (i_char == CH_MINUS);
                n_count = w_count_inc;
            end else if (w_take_zero) begin
                n_base  = (i_cfg.radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                n_acc   = '0;
                n_any   = 1'b1;
                n_count = w_count_inc;
            end else if (w_take_x) begin
                n_base  = BASE_HEX;
                n_count = w_count_inc;
            end else if (w_take_digit) begin
                n_base  = w_base;
                n_acc   = w_mac;
                n_any   = 1'b1;
                n_count = w_count_inc;
            end
        end
    end

    // Result value: negated if a minus was taken, then fitted to 32 bits.
    assign w_final = r_neg ? (~r_acc + VALUE_WIDTH'(1)) : r_acc;

    generate
        if (VALUE_WIDTH >= RESULT_WIDTH) begin : g_trunc
            assign w_value = w_final[RESULT_WIDTH-1:0];
        end else begin : g_ext
            assign w_value = {{(RESULT_WIDTH-VALUE_WIDTH){1'b0}}, w_final};
        end
    endgenerate

    // Result beat toward the output stage.
    always_comb begin
        o_beat.valid         = w_accept && w_emit;
        o_beat.res.value     = w_value;
        o_beat.res.consumed  = r_count;
        o_beat.res.converted = r_any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_base  <= '0;
            r_count <= '0;
            r_any   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_count <= n_count;
            r_any   <= n_any;
        end
    end

    // A finished number leaves the state cleared for the next one.
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit) |=> (r_phase == PH_SPACE) && (r_count == '0) && !r_any)
        else $error("number state not cleared after result");

    // Nothing past the sign is taken before the start phase is left.
    a_no_digits_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_SPACE) || (r_phase == PH_START)) |-> (!r_any && (r_acc == '0)))
        else $error("digits recorded before start phase");

    // After a prefix zero the value is still zero and the number counts as converted.
    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ZERO) |-> ((r_acc == '0) && r_any
                                  && ((r_base == BASE_OCT) || (r_base == BASE_HEX))))
        else $error("prefix phase holds bad state");

    // Within a number the count never goes down.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_emit) |=> (r_count >= $past(r_count)))
        else $error("consumed count decreased within a number");

endmodule

[hw/rtl/s2i_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2i_out_stage
// Output register of the result channel; holds one result beat until the
// sink takes it.
// ----------------------------------------------------------------------------
module s2i_out_stage import s2i_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_beat i_beat,
    output logic      o_ready,
    output logic      o_valid,
    output t_result   o_res,
    input  logic      i_ready
);

    logic    r_valid, n_valid;
    t_result r_res, n_res;

    // The register can load when empty or when its beat leaves this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (o_ready) begin
            n_valid = i_beat.valid;
            if (i_beat.valid) begin
                n_res = i_beat.res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

[hw/rtl/string_to_integer_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming strtol/strtoul style converter of ASCII characters to an integer.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle while the output register
// can take a result. Every character is handled in the cycle it is accepted:
// the accumulator multiply-add by the base in use is the one loop that closes
// there, which sets the sustained rate. The character that ends a number
// produces a result beat in the output register in the cycle after it is
// accepted; the input stalls only while that register holds a result the
// sink has not taken. There is no clearing pass after reset. Configuration
// writes are taken in every cycle and should be made between numbers.
module string_to_integer_parser import s2i_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    s2i_char_if.sink            i_char,
    s2i_result_if.source        o_result,
    s2i_cfg_if.sink             i_cfg
);

    t_cfg      w_cfg;
    t_res_beat w_beat;
    logic      w_beat_ready;
    t_result   w_res;

    // Configuration registers.
    s2i_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    // Conversion step.
    s2i_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_char.valid),
        .o_ready      (i_char.ready),
        .i_char       (i_char.char_in),
        .i_cfg        (w_cfg),
        .o_beat       (w_beat),
        .i_beat_ready (w_beat_ready)
    );

    // Result register.
    s2i_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat),
        .o_ready (w_beat_ready),
        .o_valid (o_result.valid),
        .o_res   (w_res),
        .i_ready (o_result.ready)
    );

    assign o_result.value     = w_res.value;
    assign o_result.consumed  = w_res.consumed;
    assign o_result.converted = w_res.converted;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the string to integer parser.
// ----------------------------------------------------------------------------
// A driver sends characters from a queue that the stimulus process fills. A
// software copy of the converter predicts a result for every character beat
// that ends a number, and a monitor compares each result beat with the oldest
// prediction. Both sides idle at random. Registers are written between phases,
// once every result has been returned. The phases are a short directed part,
// one long number whose value wraps, and random phases over a range of radix
// and sign settings.
// ----------------------------------------------------------------------------
module tb_top;
    import s2i_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 5;
    localparam int DRAIN_CYCLES     = 4;
    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int CHARS_PER_PHASE  = 180;
    localparam int RANDOM_PHASES    = 9;

    logic i_clk = 1'b0;
    logic i_rst_n;

    s2i_char_if   char_ch ();
    s2i_result_if result_ch ();
    s2i_cfg_if    cfg_ch ();

    string_to_integer_parser i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // Register copies, updated when a configuration beat is taken.
    logic [RADIX_WIDTH-1:0]  cfg_radix  = RADIX_RESET;
    logic                    cfg_signed = SIGNED_RESET;

    // State of the number being converted.
    t_phase                  num_phase    = PH_SPACE;
    logic                    num_negative = 1'b0;
    logic [RESULT_WIDTH-1:0] num_acc      = '0;
    logic [RADIX_WIDTH-1:0]  num_base     = '0;
    logic [COUNT_WIDTH-1:0]  num_count    = '0;
    logic                    num_taken    = 1'b0;

    // Characters waiting to be sent and results waiting to arrive.
    logic [CHAR_WIDTH-1:0]   pending_chars [$];
    t_result                 expected_results [$];
    int                      chars_in_flight = 0;

    int                      mismatch_count = 0;
    int                      idle_cycles    = 0;
    bit                      char_beat      = 1'b0;
    bit                      src_idle       = 1'b1;
    bit                      sink_idle      = 1'b1;
    int                      src_wait       = 0;
    int                      sink_wait      = 0;
    bit                      hold_request   = 1'b0;
    int                      hold_cycles    = 0;

    always #CLK_HALF i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int char_digit(input logic [CHAR_WIDTH-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
        return int'(NO_DIGIT);
    endfunction

    // Character of a digit value; letters come in either case.
    function automatic logic [CHAR_WIDTH-1:0] digit_char(input int d);
        if (d < 10) return CH_ZERO + CHAR_WIDTH'(d);
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CHAR_WIDTH'(d - 10);
    endfunction

    task automatic bump_count();
        if (num_count != COUNT_MAX) num_count++;
    endtask

    // Advance the converter by one character; a character that is not taken
    // ends the number and queues its result.
    task automatic convert_char(input logic [CHAR_WIDTH-1:0] c);
        t_result res;
        int      dig;
        if (num_phase == PH_SPACE) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
                bump_count();
                return;
            end
            if (c == CH_PLUS || (c == CH_MINUS && cfg_signed)) begin
                num_negative = (c == CH_MINUS);
                bump_count();
                num_phase = PH_START;
                return;
            end
            num_phase = PH_START;
        end
        if (num_phase == PH_START) begin
            // The base is latched by the first character after the sign.
            if (c == CH_ZERO && (cfg_radix == BASE_AUTO || cfg_radix == BASE_HEX)) begin
                num_base  = (cfg_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                num_acc   = '0;
                num_taken = 1'b1;
                bump_count();
                num_phase = PH_ZERO;
                return;
            end
            num_base  = (cfg_radix == BASE_AUTO) ? BASE_DEC : cfg_radix;
            num_phase = PH_DIGITS;
        end else if (num_phase == PH_ZERO) begin
            if (c == CH_LO_X || c == CH_UP_X) begin
                num_base = BASE_HEX;
                bump_count();
                num_phase = PH_DIGITS;
                return;
            end
            num_phase = PH_DIGITS;
        end
        dig = char_digit(c);
        if (dig < int'(num_base)) begin
            num_acc   = num_acc * RESULT_WIDTH'(num_base) + RESULT_WIDTH'(dig);
            num_taken = 1'b1;
            bump_count();
            return;
        end
        res.value     = num_negative ? (~num_acc + 1'b1) : num_acc;
        res.consumed  = num_count;
        res.converted = num_taken;
        expected_results.push_back(res);
        num_phase    = PH_SPACE;
        num_negative = 1'b0;
        num_acc      = '0;
        num_base     = '0;
        num_count    = '0;
        num_taken    = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic push_char(input logic [CHAR_WIDTH-1:0] c);
        pending_chars.push_back(c);
        chars_in_flight++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    // One number with random content under the current settings; a tenth of
    // the calls send raw noise instead.
    task automatic queue_number();
        logic [CHAR_WIDTH-1:0] blanks [3];
        int                    gen_base;
        int                    n_digits;
        int                    sign_pick;
        blanks = '{CH_SPACE, CH_TAB, CH_LF};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) push_char(CHAR_WIDTH'($urandom));
            return;
        end
        repeat ($urandom_range(0, 2)) push_char(blanks[$urandom_range(0, 2)]);
        sign_pick = $urandom_range(0, 3);
        if (sign_pick == 0) push_char(CH_PLUS);
        else if (sign_pick == 1) push_char(CH_MINUS);
        gen_base = (cfg_radix == BASE_AUTO) ? 10 : int'(cfg_radix);
        if ((cfg_radix == BASE_AUTO || cfg_radix == BASE_HEX) && $urandom_range(0, 2) == 0) begin
            push_char(CH_ZERO);
            push_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            gen_base = 16;
        end else if (cfg_radix == BASE_AUTO && $urandom_range(0, 2) == 0) begin
            push_char(CH_ZERO);
            gen_base = 8;
        end
        if (gen_base > 36) gen_base = 36;
        // Long runs of digits make the value wrap.
        n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
        repeat (n_digits) push_char(digit_char($urandom_range(0, gen_base - 1)));
        push_char($urandom_range(0, 1) ? 8'h00 : CHAR_WIDTH'($urandom));
    endtask

    // Wait until every character is taken and every result has returned.
    task automatic drain();
        do @(negedge i_clk); while (chars_in_flight != 0 || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_RADIX) cfg_radix = data[RADIX_WIDTH-1:0];
        else if (idx == CFG_SIGNED_MODE) cfg_signed = data[0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Upper data bits are random; the block keeps only the register width.
    task automatic apply_settings(input logic [RADIX_WIDTH-1:0] radix, input logic sign_ok);
        logic [CFG_DATA_W-1:0] data;
        drain();
        data = $urandom;
        data[RADIX_WIDTH-1:0] = radix;
        write_reg(CFG_RADIX, data);
        data = $urandom;
        data[0] = sign_ok;
        write_reg(CFG_SIGNED_MODE, data);
        @(posedge i_clk);
    endtask

    // Character driver.
    always @(negedge i_clk) begin
        if (!char_ch.valid || char_beat) begin
            if (src_wait > 0) begin
                src_wait--;
                char_ch.valid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
                char_ch.char_in <= pending_chars.pop_front();
                char_ch.valid   <= 1'b1;
                src_wait = src_idle ? random_gap() : 0;
            end else begin
                char_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started on request.
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles--;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_cycles  = HOLD_CYCLES;
        end
    end

    // Result ready with random stalls.
    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            result_ch.ready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
            sink_wait = sink_idle ? random_gap() : 0;
        end
    end

    // Prediction on each character beat, checking on each result beat, and
    // the watchdog.
    always @(posedge i_clk) begin
        t_result want;
        bit      result_beat;
        char_beat   = i_rst_n && char_ch.valid && char_ch.ready;
        result_beat = i_rst_n && result_ch.valid && result_ch.ready;
        if (char_beat) begin
            chars_in_flight--;
            convert_char(char_ch.char_in);
        end
        if (result_beat) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected", result_ch.value, '0);
            end else begin
                want = expected_results.pop_front();
                if (result_ch.value !== want.value)
                    report_mismatch("value", result_ch.value, want.value);
                if (result_ch.consumed !== want.consumed)
                    report_mismatch("consumed", result_ch.consumed, want.consumed);
                if (result_ch.converted !== want.converted)
                    report_mismatch("converted", result_ch.converted, want.converted);
            end
        end
        if (!i_rst_n || char_beat || result_beat || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
            $display("string_to_integer_parser regression: fail");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        logic [RADIX_WIDTH-1:0] phase_radix [RANDOM_PHASES];
        logic                   phase_signed [RANDOM_PHASES];
        i_rst_n         = 1'b0;
        char_ch.valid   = 1'b0;
        char_ch.char_in = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        phase_radix  = '{BASE_DEC, BASE_AUTO, BASE_HEX, 6'd2, 6'd36, 6'd1, 6'd37, 6'd63, 6'd0};
        phase_signed = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_radix[6]  = RADIX_WIDTH'($urandom_range(37, 62));
        phase_radix[8]  = RADIX_WIDTH'($urandom);
        phase_signed[8] = $urandom_range(0, 1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: blanks, minus sign, a sign twice, an empty number.
        push_text(" \t\n-90");
        push_char(8'hFF);
        push_text("+-");
        push_char(8'h00);

        // Detected base: hex prefix, then a leading zero selects octal.
        apply_settings(BASE_AUTO, 1'b1);
        push_text("0x1F");
        push_char(8'h00);
        push_text("0178");

        // Unsigned hex: a minus ends the number, a bare prefix gives zero.
        apply_settings(BASE_HEX, 1'b0);
        push_text("-0Xg");

        // Radix one takes zeros only; the largest radix takes every letter.
        apply_settings(6'd1, 1'b1);
        push_text("001");
        apply_settings(6'd63, 1'b1);
        push_text("zZ!");

        // One long number without gaps: the value wraps many times.
        apply_settings(BASE_DEC, 1'b1);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (12) push_char(CH_SPACE);
        repeat (40) push_char("7");
        push_char(8'h00);

        // Random phases; each ends on a NUL so the converter is idle after.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(phase_radix[p], phase_signed[p]);
            src_idle  = (p % 3) != 1;
            sink_idle = (p % 3) != 2;
            if (p == 2) begin
                @(negedge i_clk);
                hold_request = 1'b1;
                @(posedge i_clk);
            end
            while (pending_chars.size() < CHARS_PER_PHASE) queue_number();
            push_char(8'h00);
        end

        drain();
        if (mismatch_count == 0) begin
            $display("string_to_integer_parser regression: pass");
        end else begin
            $display("string_to_integer_parser regression: fail");
        end
        $finish;
    end

endmodule

[string_to_integer_parser.f]
hw/rtl/s2i_pkg.sv
hw/rtl/s2i_if.sv
hw/rtl/s2i_cfg_regs.sv
hw/rtl/s2i_core.sv
hw/rtl/s2i_out_stage.sv
hw/rtl/string_to_integer_parser.sv
verif/tb_top.sv
